// File: design/autorange_period_to_rpm_meter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the auto-ranging period to rpm meter
// Short forms for concurrent assertions with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef AUTORANGE_PERIOD_TO_RPM_METER_CORE_ASSERT_SVH
`define AUTORANGE_PERIOD_TO_RPM_METER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define ARPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included
`define ARPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg
// Types, constants and helper functions shared by the rpm meter modules.
// ----------------------------------------------------------------------------
package arpm_pkg;

    // Field and register widths
    localparam int TicksW   = 16;
    localparam int ValW     = 16;
    localparam int ClockW   = 29;
    localparam int PprW     = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 29;

    // Serial divider geometry
    localparam int NumW     = ClockW + 4;          // clock_hz * 10 fits here
    localparam int DenW     = 2 * TicksW;          // ticks * (prescaler + 1)
    localparam int CntW     = 6;
    localparam int HmW      = ValW + 3;            // tenth_hz * 6
    localparam int RpmShift = NumW - HmW;
    localparam int RatioW   = 3;

    localparam logic [CntW-1:0] DivFreqSteps = CntW'(NumW);
    localparam logic [CntW-1:0] DivRpmSteps  = CntW'(HmW);

    localparam logic [ValW-1:0] SatMax = '1;

    // Range step limits
    localparam logic [5:0] StepMin = 6'd1;
    localparam logic [5:0] StepMax = 6'd50;

    // Register reset values
    localparam logic [ClockW-1:0] ClockHzRst   = 29'd168000000;
    localparam logic [PprW-1:0]   PprRst       = 4'd6;
    localparam logic [ValW-1:0]   LowTickRst   = 16'd1000;
    localparam logic [ValW-1:0]   HighTickRst  = 16'd60000;
    localparam logic [ValW-1:0]   PrescMinRst  = 16'd0;
    localparam logic [ValW-1:0]   PrescMaxRst  = 16'd65535;
    localparam logic [ValW-1:0]   TimeoutRst   = 16'd1000;
    localparam logic [ValW-1:0]   TStepRst     = 16'd100;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_CLOCK_HZ   = 3'd0,
        CFG_PPR        = 3'd1,
        CFG_LOW_TICK   = 3'd2,
        CFG_HIGH_TICK  = 3'd3,
        CFG_PRESC_MIN  = 3'd4,
        CFG_PRESC_MAX  = 3'd5,
        CFG_TIMEOUT    = 3'd6,
        CFG_TSTEP      = 3'd7
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVF,
        ST_DOWN,
        ST_UP,
        ST_TOUT,
        ST_RPM,
        ST_DIVR,
        ST_DONE
    } t_state;

    // Divider start request
    typedef struct packed {
        logic            start;
        logic [CntW-1:0] steps;
    } t_div_ctl;

    // Rpm scaling: multiply then divide
    typedef struct packed {
        logic [RatioW-1:0] mul;
        logic [RatioW-1:0] div;
    } t_rpm_ratio;

    // Prescaler step: half the prescaler, kept within 1..50
    function automatic logic [5:0] range_step(input logic [ValW-1:0] p);
        logic [ValW-2:0] half;
        half = p[ValW-1:1];
        if (half < (ValW-1)'(StepMin)) begin
            return StepMin;
        end else if (half > (ValW-1)'(StepMax)) begin
            return StepMax;
        end else begin
            return half[5:0];
        end
    endfunction

    // Saturate a quotient to 16 bits
    function automatic logic [ValW-1:0] sat16(input logic [NumW-1:0] q);
        if (|q[NumW-1:ValW]) begin
            return SatMax;
        end else begin
            return q[ValW-1:0];
        end
    endfunction

    // Rpm ratio for each pulses-per-revolution setting; others act as six
    function automatic t_rpm_ratio rpm_ratio(input logic [PprW-1:0] ppr);
        t_rpm_ratio r;
        unique case (ppr)
            4'd1:    r = '{mul: 3'd6, div: 3'd1};
            4'd2:    r = '{mul: 3'd3, div: 3'd1};
            4'd3:    r = '{mul: 3'd2, div: 3'd1};
            4'd4:    r = '{mul: 3'd3, div: 3'd2};
            4'd5:    r = '{mul: 3'd6, div: 3'd5};
            4'd7:    r = '{mul: 3'd6, div: 3'd7};
            4'd8:    r = '{mul: 3'd3, div: 3'd4};
            4'd9:    r = '{mul: 3'd2, div: 3'd3};
            4'd10:   r = '{mul: 3'd3, div: 3'd5};
            default: r = '{mul: 3'd1, div: 3'd1};
        endcase
        return r;
    endfunction

endpackage

// File: design/autorange_period_to_rpm_meter_core.sv
// ----------------------------------------------------------------------------
// autorange_period_to_rpm_meter_core
// Reciprocal frequency meter with auto-ranging prescaler and rpm output.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: period_ticks[15:0]; tuser: capture_seen, overflow_seen
// m_axis    out  tdata: rpm, tenth_hz, prescaler_value; tuser: prescaler_changed
// cfg       in   write enable, register index, data
//
// A clean capture with non-zero ticks passes through the serial multiplier,
// the restoring divider for the frequency, and the same divider again for the
// rpm scaling, plus sequencing.
// One item is in work at a time; the next is taken while a result waits.
// Synchronous active-low reset restores register defaults and a zero prescaler.
// ----------------------------------------------------------------------------
module autorange_period_to_rpm_meter_core
    import arpm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input items
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [15:0]         i_s_axis_tdata,   // period_ticks[15:0]
    input  logic [1:0]          i_s_axis_tuser,   // capture_seen[0], overflow_seen[1]
    // Result items
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [47:0]         o_m_axis_tdata,   // rpm, tenth_hz, prescaler_value
    output logic                o_m_axis_tuser,   // prescaler_changed
    // Configuration writes
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // Configuration registers
    logic [ClockW-1:0] r_clock_hz;
    logic [PprW-1:0]   r_ppr;
    logic [ValW-1:0]   r_low_tick;
    logic [ValW-1:0]   r_high_tick;
    logic [ValW-1:0]   r_presc_min;
    logic [ValW-1:0]   r_presc_max;
    logic [ValW-1:0]   r_timeout;
    logic [ValW-1:0]   r_tstep;

    // Meter state
    t_state            r_state, n_state;
    logic [ValW-1:0]   r_presc, n_presc;
    logic [ValW-1:0]   r_idle, n_idle;
    logic [ValW-1:0]   r_tenth, n_tenth;
    logic [ValW-1:0]   r_rpm, n_rpm;
    logic [ValW-1:0]   r_start;
    logic              r_ovf;
    logic [TicksW-1:0] r_ticks;

    // Result register
    logic              r_out_valid;
    logic [47:0]       r_out_data;
    logic              r_out_user;

    // Handshake and unit control
    logic              w_accept;
    logic              w_clean;
    logic              w_zero_ticks;
    logic              w_mul_start;
    logic              w_out_load;
    t_div_ctl          w_div_ctl;
    logic [NumW-1:0]   w_div_num;
    logic [DenW-1:0]   w_div_den;
    logic              w_mul_done;
    logic [DenW-1:0]   w_product;
    logic              w_div_done;
    logic [NumW-1:0]   w_quo;

    // Arithmetic helpers
    logic [5:0]        w_step;
    logic [ValW:0]     w_up_sum;
    logic [ValW:0]     w_down_floor;
    logic [ValW:0]     w_tout_sum;
    logic [NumW-1:0]   w_clk10;
    t_rpm_ratio        w_ratio;
    logic [HmW-1:0]    w_hm;

    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_clean      = i_s_axis_tuser[0] && !i_s_axis_tuser[1];
    assign w_zero_ticks = (i_s_axis_tdata == '0);

    assign w_step       = range_step(r_presc);
    assign w_up_sum     = {1'b0, r_presc} + (ValW+1)'(w_step);
    assign w_down_floor = {1'b0, r_presc_min} + (ValW+1)'(w_step);
    assign w_tout_sum   = {1'b0, r_presc} + {1'b0, r_tstep};
    assign w_clk10      = {1'b0, r_clock_hz, 3'b000} + {3'b000, r_clock_hz, 1'b0};
    assign w_ratio      = rpm_ratio(r_ppr);
    assign w_hm         = HmW'(r_tenth) * HmW'(w_ratio.mul);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz  <= ClockHzRst;
            r_ppr       <= PprRst;
            r_low_tick  <= LowTickRst;
            r_high_tick <= HighTickRst;
            r_presc_min <= PrescMinRst;
            r_presc_max <= PrescMaxRst;
            r_timeout   <= TimeoutRst;
            r_tstep     <= TStepRst;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CLOCK_HZ:  r_clock_hz  <= i_cfg_data[ClockW-1:0];
                CFG_PPR:       r_ppr       <= i_cfg_data[PprW-1:0];
                CFG_LOW_TICK:  r_low_tick  <= i_cfg_data[ValW-1:0];
                CFG_HIGH_TICK: r_high_tick <= i_cfg_data[ValW-1:0];
                CFG_PRESC_MIN: r_presc_min <= i_cfg_data[ValW-1:0];
                CFG_PRESC_MAX: r_presc_max <= i_cfg_data[ValW-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[ValW-1:0];
                CFG_TSTEP:     r_tstep     <= i_cfg_data[ValW-1:0];
                default:       r_tstep     <= r_tstep;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (w_clean && !w_zero_ticks) begin
                        n_state = ST_MUL;
                    end else if (w_clean) begin
                        n_state = ST_DOWN;
                    end else if (i_s_axis_tuser[0]) begin
                        n_state = ST_UP;
                    end else begin
                        n_state = ST_TOUT;
                    end
                end
            end
            ST_MUL:  if (w_mul_done) n_state = ST_DIVF;
            ST_DIVF: if (w_div_done) n_state = ST_DOWN;
            ST_DOWN: n_state = ST_UP;
            ST_UP:   n_state = ST_TOUT;
            ST_TOUT: n_state = ST_RPM;
            ST_RPM:  n_state = ST_DIVR;
            ST_DIVR: if (w_div_done) n_state = ST_DONE;
            ST_DONE: if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mul_start     = 1'b0;
        w_out_load      = 1'b0;
        w_div_ctl       = '{start: 1'b0, steps: DivFreqSteps};
        w_div_num       = w_clk10;
        w_div_den       = w_product;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_mul_start     = w_accept && w_clean && !w_zero_ticks;
            end
            ST_MUL: begin
                w_div_ctl = '{start: w_mul_done, steps: DivFreqSteps};
            end
            ST_RPM: begin
                w_div_ctl = '{start: 1'b1, steps: DivRpmSteps};
                w_div_num = {w_hm, RpmShift'(0)};
                w_div_den = DenW'(w_ratio.div);
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // Next values of the meter state
    always_comb begin
        n_presc = r_presc;
        n_idle  = r_idle;
        n_tenth = r_tenth;
        n_rpm   = r_rpm;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_clean && w_zero_ticks) begin
                    n_tenth = SatMax;
                end
            end
            ST_DIVF: begin
                if (w_div_done) begin
                    n_tenth = sat16(w_quo);
                end
            end
            // Clean capture: clear the idle count, step down on short periods
            ST_DOWN: begin
                n_idle = '0;
                if (r_ticks < r_low_tick && {1'b0, r_presc} >= w_down_floor) begin
                    n_presc = r_presc - ValW'(w_step);
                end
            end
            // Step up on long periods or an overflowed capture
            ST_UP: begin
                if ((r_ovf || r_ticks > r_high_tick) && r_presc < r_presc_max) begin
                    n_presc = w_up_sum[ValW] ? SatMax : w_up_sum[ValW-1:0];
                end
            end
            // Count idle polls; on timeout drop the frequency and widen range
            ST_TOUT: begin
                if (r_idle < r_timeout) begin
                    n_idle = r_idle + 1'b1;
                end else begin
                    n_tenth = '0;
                    if (w_tout_sum < {1'b0, r_presc_max}) begin
                        n_presc = w_tout_sum[ValW-1:0];
                    end
                end
            end
            ST_DIVR: begin
                if (w_div_done) begin
                    n_rpm = sat16(w_quo);
                end
            end
            default: begin
                n_rpm = r_rpm;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_presc <= PrescMinRst;
            r_idle  <= '0;
            r_tenth <= '0;
        end else begin
            r_state <= n_state;
            r_presc <= n_presc;
            r_idle  <= n_idle;
            r_tenth <= n_tenth;
        end
    end

    // Item payload and rpm result
    always_ff @(posedge i_clk) begin
        r_rpm <= n_rpm;
        if (w_accept) begin
            r_start <= r_presc;
            r_ovf   <= i_s_axis_tuser[1];
            r_ticks <= i_s_axis_tdata;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_presc, r_tenth, r_rpm};
            r_out_user <= (r_presc != r_start);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    arpm_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   ({1'b0, r_presc} + (ValW+1)'(1)),
        .i_mplier  (i_s_axis_tdata),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    arpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

endmodule

// File: design/arpm_mul.sv
// ----------------------------------------------------------------------------
// arpm_mul
// Shift-and-add multiplier: one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module arpm_mul
    import arpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ValW:0]     i_mcand,
    input  logic [TicksW-1:0] i_mplier,
    output logic              o_done,
    output logic [DenW-1:0]   o_product
);

    localparam int CntMW = $clog2(TicksW);

    logic              r_busy;
    logic              r_done;
    logic [CntMW-1:0]  r_cnt;
    logic [ValW:0]     r_mcand;
    logic [ValW:0]     r_hi;
    logic [TicksW-1:0] r_lo;
    logic [ValW+1:0]   w_sum;

    // Add the multiplicand when the current multiplier bit is set
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntMW'(TicksW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the partial product right one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= w_sum[ValW+1:1];
            r_lo <= {w_sum[0], r_lo[TicksW-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[DenW-TicksW-1:0], r_lo};

endmodule

// File: design/arpm_div.sv
// ----------------------------------------------------------------------------
// arpm_div
// Restoring divider: one quotient bit per cycle, step count set per request.
// ----------------------------------------------------------------------------
module arpm_div
    import arpm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_ctl        i_ctl,
    input  logic [NumW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    output logic            o_done,
    output logic [NumW-1:0] o_quo
);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DenW-1:0] r_rem;
    logic [DenW-1:0] r_den;
    logic [NumW-1:0] r_num;
    logic [NumW-1:0] r_quo;
    logic [DenW+1:0] w_diff;
    logic            w_fit;

    // Trial subtract of the divisor from the shifted remainder
    assign w_diff = {1'b0, r_rem, r_num[NumW-1]} - {2'b00, r_den};
    assign w_fit  = !w_diff[DenW+1];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps - 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: keep the difference when the divisor fits, else shift in the bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DenW-1:0] : {r_rem[DenW-2:0], r_num[NumW-1]};
            r_num <= {r_num[NumW-2:0], 1'b0};
            r_quo <= {r_quo[NumW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: design/arpm_chk.sv
// ----------------------------------------------------------------------------
// arpm_chk
// Port-level checks for the rpm meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "autorange_period_to_rpm_meter_core_assert.svh"

module arpm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // A stalled result holds its value
    `ARPM_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "result changed while stalled")

    // Reset leaves no result and an open input
    `ARPM_ASSERT_ALWAYS(a_reset_state, i_clk,
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready,
        "bad state after reset")

    // One item in work at a time
    `ARPM_ASSERT(a_one_item, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready,
        "input taken twice in a row")

    // Zero frequency gives zero rpm
    `ARPM_ASSERT(a_zero_rpm, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[31:16] == 16'd0 |-> o_m_axis_tdata[15:0] == 16'd0,
        "rpm without frequency")

endmodule

bind autorange_period_to_rpm_meter_core arpm_chk u_arpm_chk (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: rpm meter core testbench
// Sends timer polls to the meter and predicts every result in step. The
// prediction tracks prescaler, idle count and last frequency. It checks each
// result field by field in order. Random stalls fall on both streams, and one
// long output hold-off fills the core up.
// ----------------------------------------------------------------------------
module tb;
    import arpm_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned TAIL_CYCLES = 100;
    localparam int unsigned STALL_PCT   = 33;
    localparam int unsigned VAL_MAX     = 65535;

    // One result item as the core reports it
    typedef struct packed {
        logic [15:0] rpm;
        logic [15:0] tenth_hz;
        logic [15:0] prescaler;
        logic        changed;
    } t_reading;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [15:0]         i_s_axis_tdata  = '0;  // period_ticks[15:0]
    logic [1:0]          i_s_axis_tuser  = '0;  // capture_seen[0], overflow_seen[1]
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [47:0]         o_m_axis_tdata;        // rpm, tenth_hz, prescaler_value
    logic                o_m_axis_tuser;        // prescaler_changed
    logic                i_cfg_we        = 1'b0;
    t_cfg_idx            i_cfg_idx       = CFG_CLOCK_HZ;
    logic [CfgDataW-1:0] i_cfg_data      = '0;

    // Register copies for prediction
    int unsigned clock_hz_reg   = ClockHzRst;
    int unsigned ppr_reg        = PprRst;
    int unsigned low_ticks_reg  = LowTickRst;
    int unsigned high_ticks_reg = HighTickRst;
    int unsigned presc_min_reg  = PrescMinRst;
    int unsigned presc_max_reg  = PrescMaxRst;
    int unsigned timeout_reg    = TimeoutRst;
    int unsigned tout_step_reg  = TStepRst;

    // Meter state for prediction
    int unsigned presc      = PrescMinRst;
    int unsigned idle_polls = 0;
    int unsigned hz_tenths  = 0;

    t_reading    expected_readings[$];
    int unsigned polls_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    bit          idling_on    = 1'b1;
    bit          sink_hold    = 1'b0;
    event        hold_ev;

    autorange_period_to_rpm_meter_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clip to the 16-bit output range
    function automatic int unsigned clip16(longint unsigned v);
        return (v > VAL_MAX) ? VAL_MAX : int'(v);
    endfunction

    // Prescaler adjustment: half the prescaler, kept within 1..50
    function automatic int unsigned range_stride(int unsigned p);
        int unsigned s;
        s = p / 2;
        if (s < StepMin) begin
            s = StepMin;
        end
        if (s > StepMax) begin
            s = StepMax;
        end
        return s;
    endfunction

    // Advance the meter by one poll and return the reading it reports
    function automatic t_reading predict_reading(bit cap, bit ovf, int unsigned ticks);
        t_reading        res;
        longint unsigned den;
        longint unsigned quo;
        int unsigned     start;
        int unsigned     rpm_raw;
        start = presc;
        if (cap && !ovf) begin
            den = 64'(ticks) * 64'(presc + 1);
            if (den == 0) begin
                hz_tenths = VAL_MAX;
            end else begin
                quo = (64'(clock_hz_reg) * 10) / den;
                hz_tenths = clip16(quo);
            end
            idle_polls = 0;
            if (ticks < low_ticks_reg && presc >= presc_min_reg + range_stride(presc)) begin
                presc -= range_stride(presc);
            end
            if (ticks > high_ticks_reg && presc < presc_max_reg) begin
                presc = clip16(64'(presc) + range_stride(presc));
            end
        end else if (cap && presc < presc_max_reg) begin
            presc = clip16(64'(presc) + range_stride(presc));
        end
        // Count idle polls, or zero the frequency once timed out
        if (idle_polls < timeout_reg) begin
            idle_polls++;
        end else begin
            hz_tenths = 0;
            if (presc + tout_step_reg < presc_max_reg) begin
                presc += tout_step_reg;
            end
        end
        case (ppr_reg)
            1:       rpm_raw = hz_tenths * 6;
            2:       rpm_raw = hz_tenths * 3;
            3:       rpm_raw = hz_tenths * 2;
            4:       rpm_raw = (hz_tenths * 3) / 2;
            5:       rpm_raw = (hz_tenths * 6) / 5;
            7:       rpm_raw = (hz_tenths * 6) / 7;
            8:       rpm_raw = (hz_tenths * 3) / 4;
            9:       rpm_raw = (hz_tenths * 2) / 3;
            10:      rpm_raw = (hz_tenths * 3) / 5;
            default: rpm_raw = hz_tenths;
        endcase
        res.rpm       = 16'(clip16(rpm_raw));
        res.tenth_hz  = 16'(hz_tenths);
        res.prescaler = 16'(presc);
        res.changed   = (presc != start);
        return res;
    endfunction

    // Write one register and mirror it in the prediction
    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CfgDataW'(value);
        case (idx)
            CFG_CLOCK_HZ:  clock_hz_reg   = value & 32'h1FFF_FFFF;
            CFG_PPR:       ppr_reg        = value & 32'hF;
            CFG_LOW_TICK:  low_ticks_reg  = value & 32'hFFFF;
            CFG_HIGH_TICK: high_ticks_reg = value & 32'hFFFF;
            CFG_PRESC_MIN: presc_min_reg  = value & 32'hFFFF;
            CFG_PRESC_MAX: presc_max_reg  = value & 32'hFFFF;
            CFG_TIMEOUT:   timeout_reg    = value & 32'hFFFF;
            CFG_TSTEP:     tout_step_reg  = value & 32'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(int unsigned clk_hz, int unsigned ppr,
                                  int unsigned low_t, int unsigned high_t,
                                  int unsigned pmin, int unsigned pmax,
                                  int unsigned tout, int unsigned tstep);
        write_reg(CFG_CLOCK_HZ, clk_hz);
        write_reg(CFG_PPR, ppr);
        write_reg(CFG_LOW_TICK, low_t);
        write_reg(CFG_HIGH_TICK, high_t);
        write_reg(CFG_PRESC_MIN, pmin);
        write_reg(CFG_PRESC_MAX, pmax);
        write_reg(CFG_TIMEOUT, tout);
        write_reg(CFG_TSTEP, tstep);
    endtask

    // Offer one poll item, hold it until taken, then queue its reading
    task automatic send_poll(bit cap, bit ovf, logic [15:0] ticks);
        if (idling_on && $urandom_range(99) < STALL_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ticks;
        i_s_axis_tuser  <= {ovf, cap};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_readings.push_back(predict_reading(cap, ovf, ticks));
        polls_sent++;
    endtask

    // Drop valid and wait until every queued reading has come back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_seen != polls_sent);
    endtask

    // Mixed polls: mostly a tracked signal, plus overflows, idle polls and odd ticks
    task automatic run_phase(int unsigned count, int unsigned period);
        bit              cap;
        bit              ovf;
        logic [15:0]     ticks;
        int unsigned     kind;
        longint unsigned scaled;
        repeat (count) begin
            kind  = $urandom_range(99);
            cap   = 1'b1;
            ovf   = 1'b0;
            ticks = 16'($urandom());
            if (kind < 60) begin
                // ticks follow the current prescaler; too slow a signal overflows
                scaled = period / (presc + 1) + $urandom_range(0, 3);
                if (scaled > VAL_MAX) begin
                    ovf = 1'b1;
                end else begin
                    ticks = 16'(scaled);
                end
            end else if (kind < 70) begin
                ovf = 1'b1;
            end else if (kind < 85) begin
                cap = 1'b0;
                ovf = 1'($urandom_range(1));
            end else if (kind < 90) begin
                ticks = '0;
            end else if (kind < 95) begin
                ticks = 16'($urandom_range(1, 2000));
            end
            send_poll(cap, ovf, ticks);
        end
    endtask

    // Reset settings: idle poll with stray overflow, zero period, range steps
    task automatic test_reset_defaults();
        send_poll(1'b0, 1'b1, 16'hFFFF);
        send_poll(1'b1, 1'b0, 16'h0000);
        send_poll(1'b1, 1'b0, 16'hFFFF);
        send_poll(1'b1, 1'b0, 16'h0001);
        send_poll(1'b1, 1'b1, 16'h5555);
        send_poll(1'b1, 1'b0, 16'hAAAA);
    endtask

    // Pulses-per-revolution settings 0 to 11 and 15, unknown ones included
    task automatic test_rpm_scaling();
        int unsigned ppr_list[13] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 15};
        drain_results();
        write_reg(CFG_CLOCK_HZ, 1000000);
        foreach (ppr_list[i]) begin
            drain_results();
            write_reg(CFG_PPR, ppr_list[i]);
            send_poll(1'b1, 1'b0, 16'd500);
        end
    endtask

    // Zero timeout limit: every poll times out and grows the prescaler to the top
    task automatic test_timeout_growth();
        drain_results();
        write_reg(CFG_TIMEOUT, 0);
        write_reg(CFG_TSTEP, 30000);
        repeat (3) send_poll(1'b0, 1'b0, 16'($urandom()));
        drain_results();
        write_reg(CFG_TSTEP, 5534);
        send_poll(1'b0, 1'b0, 16'($urandom()));
        send_poll(1'b1, 1'b1, 16'($urandom()));
    endtask

    // Random phases across a spread of settings, extremes among them
    task automatic test_tracking();
        drain_results();
        idling_on = 1'b0;
        apply_settings(ClockHzRst, PprRst, LowTickRst, HighTickRst, 0, VAL_MAX, 20, 100);
        run_phase(80, $urandom_range(2000, 20000000));
        drain_results();
        idling_on = 1'b1;
        apply_settings(1, 1, 0, VAL_MAX, 0, VAL_MAX, 0, 0);
        run_phase(50, $urandom_range(2000, 20000000));
        drain_results();
        apply_settings(400000000, 10, VAL_MAX, 0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        run_phase(50, $urandom_range(2000, 20000000));
        drain_results();
        apply_settings(400000000, 0, VAL_MAX, VAL_MAX, 0, 0, 5, 7);
        run_phase(50, $urandom_range(2000, 20000000));
        drain_results();
        apply_settings(50000000, 15, 2000, 40000, 10, 5000, 3, 500);
        run_phase(50, $urandom_range(2000, 20000000));
        repeat (2) begin
            drain_results();
            apply_settings($urandom_range(1, 400000000), $urandom_range(0, 15),
                           $urandom_range(0, VAL_MAX), $urandom_range(0, VAL_MAX),
                           $urandom_range(0, 200), $urandom_range(0, VAL_MAX),
                           $urandom_range(0, 40), $urandom_range(0, VAL_MAX));
            run_phase(50, $urandom_range(2000, 20000000));
        end
    endtask

    // Hold the output off while polls keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain_results();
        idling_on = 1'b0;
        -> hold_ev;
        run_phase(12, $urandom_range(2000, 20000000));
        idling_on = 1'b1;
    endtask

    // Long output hold-off, counted here
    initial begin
        forever begin
            @(hold_ev);
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            sink_hold = 1'b0;
        end
    end

    // Take result items and compare each with the oldest reading waiting
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
                $error("result with no poll waiting: tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                if (o_m_axis_tdata[15:0] !== want.rpm) begin
                    $error("rpm: expected %0d, got %0d", want.rpm, o_m_axis_tdata[15:0]);
                    errors++;
                end
                if (o_m_axis_tdata[31:16] !== want.tenth_hz) begin
                    $error("tenth_hz: expected %0d, got %0d",
                           want.tenth_hz, o_m_axis_tdata[31:16]);
                    errors++;
                end
                if (o_m_axis_tdata[47:32] !== want.prescaler) begin
                    $error("prescaler_value: expected %0d, got %0d",
                           want.prescaler, o_m_axis_tdata[47:32]);
                    errors++;
                end
                if (o_m_axis_tuser !== want.changed) begin
                    $error("prescaler_changed: expected %0d, got %0d",
                           want.changed, o_m_axis_tuser);
                    errors++;
                end
            end
        end
        i_m_axis_tready <= !sink_hold && (!idling_on || $urandom_range(99) >= STALL_PCT);
    end

    // Cycle counter: stop a run that hangs
    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_rpm_scaling();
        test_timeout_growth();
        test_tracking();
        test_output_backpressure();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
